>>> design/tgr_pkg.sv
// Shared types and codes for the touch gesture recognizer.
package tgr_pkg;

    // Input event codes
    localparam logic [1:0] REQ_DOWN   = 2'd0;
    localparam logic [1:0] REQ_MOTION = 2'd1;
    localparam logic [1:0] REQ_UP     = 2'd2;

    // Result kind codes
    localparam logic [2:0] KIND_DOWN   = 3'd0;
    localparam logic [2:0] KIND_MOTION = 3'd1;
    localparam logic [2:0] KIND_SCALE  = 3'd2;
    localparam logic [2:0] KIND_LINE   = 3'd3;
    localparam logic [2:0] KIND_CLICK  = 3'd4;
    localparam logic [2:0] KIND_UP     = 3'd5;

    // Line threshold after reset (0.06 in Q2.14)
    localparam logic [15:0] THRESH_RESET = 16'd983;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DOWN_WR,
        ST_MOVE_WR,
        ST_SQ_X,
        ST_SQ_Y,
        ST_THR,
        ST_SQRT_INIT,
        ST_SQRT_STEP,
        ST_PAIR,
        ST_REMOVE,
        ST_EMIT_A,
        ST_HOLD_A,
        ST_EMIT_B,
        ST_HOLD_B
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCAN,
        OP_DOWN_WR,
        OP_MOVE_WR,
        OP_SQ_X,
        OP_SQ_Y,
        OP_THR,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_PAIR,
        OP_REMOVE,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        RES_DOWN,
        RES_MOTION,
        RES_SCALE,
        RES_GESTURE,
        RES_UP
    } res_t;

    typedef struct packed {
        dp_op_t op;
        res_t   res;
        logic   last;
        logic   use_pair;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       scan_done;
        logic       found;
        logic       count_is_two;
        logic       pair_valid;
        logic       peak_is_one;
        logic       sqrt_done;
    } dp_stat_t;

endpackage

>>> design/tgr_datapath.sv
// Finger table, shared squarer, iterative square root and result register.
module tgr_datapath #(
    parameter int MAX_FINGERS = 8,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [1:0]                    req_type,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] move_dx,
    input  logic signed [COORD_WIDTH-1:0] move_dy,
    input  logic [7:0]                    finger_id,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_data,
    input  tgr_pkg::dp_cmd_t              cmd,
    output tgr_pkg::dp_stat_t             stat,
    output logic [2:0]                    kind,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] end_x,
    output logic signed [COORD_WIDTH-1:0] end_y,
    output logic [7:0]                    out_finger,
    output logic signed [COORD_WIDTH-1:0] delta_x,
    output logic signed [COORD_WIDTH-1:0] delta_y,
    output logic signed [COORD_WIDTH+1:0] scale,
    output logic                          last
);

    localparam int W    = COORD_WIDTH;
    localparam int IDXW = $clog2(MAX_FINGERS);
    localparam int CNTW = $clog2(MAX_FINGERS + 1);
    localparam int MW   = (W + 1 > 17) ? W + 1 : 17;
    localparam int SQW  = 2 * W + 1;
    localparam int RADW = 2 * W + 2;
    localparam int CMPW = (SQW > 32) ? SQW : 32;
    localparam int ITW  = $clog2(W + 2);

    // Latched input item
    logic [1:0]          req_reg;
    logic signed [W-1:0] px_reg, py_reg, mdx_reg, mdy_reg;
    logic [7:0]          fid_reg;

    // Finger table, ordered, count entries valid
    logic [7:0]          tid  [MAX_FINGERS];
    logic signed [W-1:0] tdnx [MAX_FINGERS];
    logic signed [W-1:0] tdny [MAX_FINGERS];
    logic signed [W-1:0] tcurx[MAX_FINGERS];
    logic signed [W-1:0] tcury[MAX_FINGERS];

    logic [CNTW-1:0] cnt_reg, cnt_next, peak_reg;
    logic [CNTW-1:0] scan_reg;
    logic            found_reg;
    logic [IDXW-1:0] slot_reg;
    logic signed [W-1:0] sdnx_reg, sdny_reg;

    logic [15:0]     thr_reg;
    logic [SQW-1:0]  sq_reg;
    logic [31:0]     thr2_reg;
    logic [RADW-1:0] rad_reg;
    logic [W+2:0]    rem_reg;
    logic [W:0]      root_reg;
    logic [ITW-1:0]  iter_reg;
    logic [W:0]      pd_reg;
    logic            pdv_reg;
    logic signed [W+1:0] sc_reg;

    logic [IDXW-1:0]      scan_idx;
    logic signed [W:0]    diff;
    logic signed [MW-1:0] mult_a;
    logic signed [2*MW-1:0] prod;
    logic [W+2:0]         remt, trial;
    logic                 far;

    assign scan_idx = scan_reg[IDXW-1:0];

    // Operand of the shared squarer
    always_comb
    begin
        priority if (cmd.op == tgr_pkg::OP_THR)
        begin
            diff = '0;
        end
        else if (cmd.use_pair)
        begin
            diff = (cmd.op == tgr_pkg::OP_SQ_X)
                 ? {tcurx[1][W-1], tcurx[1]} - {tcurx[0][W-1], tcurx[0]}
                 : {tcury[1][W-1], tcury[1]} - {tcury[0][W-1], tcury[0]};
        end
        else
        begin
            diff = (cmd.op == tgr_pkg::OP_SQ_X)
                 ? {px_reg[W-1], px_reg} - {sdnx_reg[W-1], sdnx_reg}
                 : {py_reg[W-1], py_reg} - {sdny_reg[W-1], sdny_reg};
        end
        if (cmd.op == tgr_pkg::OP_THR)
            mult_a = MW'(signed'({1'b0, thr_reg}));
        else
            mult_a = MW'(diff);
        prod = mult_a * mult_a;
    end

    // One root digit per step
    assign remt  = {rem_reg[W:0], rad_reg[RADW-1:RADW-2]};
    assign trial = {root_reg, 2'b01};
    assign far   = CMPW'(sq_reg) > CMPW'(thr2_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.op == tgr_pkg::OP_DOWN_WR && !found_reg
            && cnt_reg < CNTW'(MAX_FINGERS))
            cnt_next = cnt_reg + 1'b1;
        else if (cmd.op == tgr_pkg::OP_REMOVE && found_reg)
            cnt_next = cnt_reg - 1'b1;
    end

    // Control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            peak_reg  <= '0;
            pdv_reg   <= 1'b0;
            found_reg <= 1'b0;
            scan_reg  <= '0;
            iter_reg  <= '0;
            thr_reg   <= tgr_pkg::THRESH_RESET;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cfg_we)
                thr_reg <= cfg_data;
            if (load)
            begin
                found_reg <= 1'b0;
                scan_reg  <= '0;
            end
            unique case (cmd.op)
                tgr_pkg::OP_SCAN:
                begin
                    if (!found_reg && scan_reg != cnt_reg)
                    begin
                        if (tid[scan_idx] == fid_reg)
                            found_reg <= 1'b1;
                        else
                            scan_reg <= scan_reg + 1'b1;
                    end
                end
                tgr_pkg::OP_DOWN_WR:
                begin
                    if (peak_reg < cnt_next)
                        peak_reg <= cnt_next;
                end
                tgr_pkg::OP_MOVE_WR:
                begin
                    if (cnt_reg != CNTW'(2))
                        pdv_reg <= 1'b0;
                end
                tgr_pkg::OP_SQRT_INIT: iter_reg <= '0;
                tgr_pkg::OP_SQRT_STEP: iter_reg <= iter_reg + 1'b1;
                tgr_pkg::OP_PAIR:      pdv_reg  <= 1'b1;
                tgr_pkg::OP_REMOVE:
                begin
                    pdv_reg <= 1'b0;
                    if (cnt_next == '0)
                        peak_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Payload: input latch, table, arithmetic, result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_type;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            mdx_reg <= move_dx;
            mdy_reg <= move_dy;
            fid_reg <= finger_id;
        end
        unique case (cmd.op)
            tgr_pkg::OP_SCAN:
            begin
                slot_reg <= scan_idx;
                sdnx_reg <= tdnx[scan_idx];
                sdny_reg <= tdny[scan_idx];
            end
            tgr_pkg::OP_DOWN_WR:
            begin
                if (!found_reg && cnt_reg < CNTW'(MAX_FINGERS))
                begin
                    tid  [cnt_reg[IDXW-1:0]] <= fid_reg;
                    tdnx [cnt_reg[IDXW-1:0]] <= px_reg;
                    tdny [cnt_reg[IDXW-1:0]] <= py_reg;
                    tcurx[cnt_reg[IDXW-1:0]] <= px_reg;
                    tcury[cnt_reg[IDXW-1:0]] <= py_reg;
                end
            end
            tgr_pkg::OP_MOVE_WR:
            begin
                if (found_reg)
                begin
                    tcurx[slot_reg] <= px_reg;
                    tcury[slot_reg] <= py_reg;
                end
            end
            tgr_pkg::OP_SQ_X: sq_reg   <= prod[SQW-1:0];
            tgr_pkg::OP_SQ_Y: sq_reg   <= sq_reg + prod[SQW-1:0];
            tgr_pkg::OP_THR:  thr2_reg <= prod[31:0];
            tgr_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= {1'b0, sq_reg};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            tgr_pkg::OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[RADW-3:0], 2'b00};
                if (remt >= trial)
                begin
                    rem_reg  <= remt - trial;
                    root_reg <= {root_reg[W-1:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= remt;
                    root_reg <= {root_reg[W-1:0], 1'b0};
                end
            end
            tgr_pkg::OP_PAIR:
            begin
                sc_reg <= signed'({1'b0, root_reg}) - signed'({1'b0, pd_reg});
                pd_reg <= root_reg;
            end
            tgr_pkg::OP_REMOVE:
            begin
                for (int i = 0; i < MAX_FINGERS - 1; i++)
                begin
                    if (found_reg && IDXW'(i) >= slot_reg && CNTW'(i + 1) < cnt_reg)
                    begin
                        tid[i]   <= tid[i+1];
                        tdnx[i]  <= tdnx[i+1];
                        tdny[i]  <= tdny[i+1];
                        tcurx[i] <= tcurx[i+1];
                        tcury[i] <= tcury[i+1];
                    end
                end
            end
            tgr_pkg::OP_EMIT:
            begin
                out_x      <= px_reg;
                out_y      <= py_reg;
                end_x      <= '0;
                end_y      <= '0;
                out_finger <= fid_reg;
                delta_x    <= '0;
                delta_y    <= '0;
                scale      <= '0;
                last       <= cmd.last;
                unique case (cmd.res)
                    tgr_pkg::RES_DOWN: kind <= tgr_pkg::KIND_DOWN;
                    tgr_pkg::RES_MOTION:
                    begin
                        kind    <= tgr_pkg::KIND_MOTION;
                        delta_x <= mdx_reg;
                        delta_y <= mdy_reg;
                    end
                    tgr_pkg::RES_SCALE:
                    begin
                        kind       <= tgr_pkg::KIND_SCALE;
                        out_x      <= '0;
                        out_y      <= '0;
                        out_finger <= '0;
                        scale      <= sc_reg;
                    end
                    tgr_pkg::RES_GESTURE:
                    begin
                        if (far)
                        begin
                            kind  <= tgr_pkg::KIND_LINE;
                            out_x <= sdnx_reg;
                            out_y <= sdny_reg;
                            end_x <= px_reg;
                            end_y <= py_reg;
                        end
                        else
                            kind <= tgr_pkg::KIND_CLICK;
                    end
                    default: kind <= tgr_pkg::KIND_UP;
                endcase
            end
            default: ;
        endcase
    end

    // Status to the controller
    always_comb
    begin
        stat.req          = req_reg;
        stat.scan_done    = found_reg || (scan_reg == cnt_reg);
        stat.found        = found_reg;
        stat.count_is_two = (cnt_reg == CNTW'(2));
        stat.pair_valid   = pdv_reg;
        stat.peak_is_one  = (peak_reg == CNTW'(1));
        stat.sqrt_done    = (iter_reg == ITW'(W + 1));
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_FINGERS))
        else $error("finger count above table size");

    a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= cnt_reg)
        else $error("session peak below finger count");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= cnt_reg || load)
        else $error("scan index past table fill");

endmodule

>>> design/tgr_ctrl.sv
// Sequencing state machine for the touch gesture recognizer.
module tgr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              load,
    output logic              out_valid,
    input  logic              out_stall,
    input  tgr_pkg::dp_stat_t stat,
    output tgr_pkg::dp_cmd_t  cmd
);

    tgr_pkg::state_t state_reg, state_next;
    logic two_reg, two_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgr_pkg::ST_IDLE;
            two_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            two_reg   <= two_next;
        end
    end

    assign in_stall  = (state_reg != tgr_pkg::ST_IDLE);
    assign load      = in_valid && !in_stall;
    assign out_valid = (state_reg == tgr_pkg::ST_HOLD_A) || (state_reg == tgr_pkg::ST_HOLD_B);

    // Next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        two_next     = two_reg;
        cmd.op       = tgr_pkg::OP_NONE;
        cmd.res      = tgr_pkg::RES_UP;
        cmd.last     = 1'b1;
        cmd.use_pair = (stat.req == tgr_pkg::REQ_MOTION);
        unique case (state_reg)
            tgr_pkg::ST_IDLE:
            begin
                two_next = 1'b0;
                if (load)
                    state_next = tgr_pkg::ST_SCAN;
            end
            tgr_pkg::ST_SCAN:
            begin
                cmd.op = tgr_pkg::OP_SCAN;
                if (stat.scan_done)
                begin
                    priority case (stat.req)
                        tgr_pkg::REQ_DOWN:   state_next = tgr_pkg::ST_DOWN_WR;
                        tgr_pkg::REQ_MOTION: state_next = tgr_pkg::ST_MOVE_WR;
                        tgr_pkg::REQ_UP:
                            state_next = stat.found ? tgr_pkg::ST_SQ_X : tgr_pkg::ST_REMOVE;
                        default:             state_next = tgr_pkg::ST_IDLE;
                    endcase
                end
            end
            tgr_pkg::ST_DOWN_WR:
            begin
                cmd.op     = tgr_pkg::OP_DOWN_WR;
                state_next = tgr_pkg::ST_EMIT_B;
            end
            tgr_pkg::ST_MOVE_WR:
            begin
                cmd.op     = tgr_pkg::OP_MOVE_WR;
                state_next = stat.count_is_two ? tgr_pkg::ST_SQ_X : tgr_pkg::ST_EMIT_B;
            end
            tgr_pkg::ST_SQ_X:
            begin
                cmd.op     = tgr_pkg::OP_SQ_X;
                state_next = tgr_pkg::ST_SQ_Y;
            end
            tgr_pkg::ST_SQ_Y:
            begin
                cmd.op     = tgr_pkg::OP_SQ_Y;
                state_next = (stat.req == tgr_pkg::REQ_MOTION)
                           ? tgr_pkg::ST_SQRT_INIT : tgr_pkg::ST_THR;
            end
            tgr_pkg::ST_THR:
            begin
                cmd.op     = tgr_pkg::OP_THR;
                state_next = stat.peak_is_one ? tgr_pkg::ST_EMIT_A : tgr_pkg::ST_REMOVE;
            end
            tgr_pkg::ST_SQRT_INIT:
            begin
                cmd.op     = tgr_pkg::OP_SQRT_INIT;
                state_next = tgr_pkg::ST_SQRT_STEP;
            end
            tgr_pkg::ST_SQRT_STEP:
            begin
                if (stat.sqrt_done)
                    state_next = tgr_pkg::ST_PAIR;
                else
                    cmd.op = tgr_pkg::OP_SQRT_STEP;
            end
            tgr_pkg::ST_PAIR:
            begin
                cmd.op     = tgr_pkg::OP_PAIR;
                two_next   = stat.pair_valid;
                state_next = stat.pair_valid ? tgr_pkg::ST_EMIT_A : tgr_pkg::ST_EMIT_B;
            end
            tgr_pkg::ST_REMOVE:
            begin
                cmd.op     = tgr_pkg::OP_REMOVE;
                state_next = tgr_pkg::ST_EMIT_B;
            end
            tgr_pkg::ST_EMIT_A:
            begin
                cmd.op     = tgr_pkg::OP_EMIT;
                cmd.last   = 1'b0;
                cmd.res    = (stat.req == tgr_pkg::REQ_MOTION)
                           ? tgr_pkg::RES_MOTION : tgr_pkg::RES_GESTURE;
                state_next = tgr_pkg::ST_HOLD_A;
            end
            tgr_pkg::ST_HOLD_A:
            begin
                if (!out_stall)
                    state_next = (stat.req == tgr_pkg::REQ_MOTION)
                               ? tgr_pkg::ST_EMIT_B : tgr_pkg::ST_REMOVE;
            end
            tgr_pkg::ST_EMIT_B:
            begin
                cmd.op = tgr_pkg::OP_EMIT;
                priority case (stat.req)
                    tgr_pkg::REQ_DOWN:   cmd.res = tgr_pkg::RES_DOWN;
                    tgr_pkg::REQ_MOTION:
                        cmd.res = two_reg ? tgr_pkg::RES_SCALE : tgr_pkg::RES_MOTION;
                    default:             cmd.res = tgr_pkg::RES_UP;
                endcase
                state_next = tgr_pkg::ST_HOLD_B;
            end
            tgr_pkg::ST_HOLD_B:
            begin
                if (!out_stall)
                    state_next = tgr_pkg::ST_IDLE;
            end
            default: state_next = tgr_pkg::ST_IDLE;
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while taking an item");

    a_hold_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    a_emit_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tgr_pkg::ST_EMIT_B) |=> (state_reg == tgr_pkg::ST_HOLD_B))
        else $error("final result not presented");

endmodule

>>> design/touch_gesture_recognizer.sv
// Top level of the touch gesture recognizer: controller plus datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_valid / in_stall    | req_type pos_x pos_y move_dx move_dy finger_id
//  output   | out_valid / out_stall  | kind out_x out_y end_x end_y out_finger
//           |                        | delta_x delta_y scale last
//  config   | cfg_valid / cfg_ready  | cfg_data (line threshold)
//
// One item at a time: the item is accepted, then the finger table is searched
// for its id (up to MAX_FINGERS entries). A down or motion then writes the
// table; a two-finger motion squares the distance between the fingers and
// takes COORD_WIDTH+1 root steps; an up, when the id is known, squares the
// distance from its down position and the threshold, then removes the entry.
// Each result is registered, then held until taken. Asynchronous active-low
// reset empties the table and sets the threshold to 983. in_stall is high from
// acceptance until the last result of the item is taken.
module touch_gesture_recognizer #(
    parameter int MAX_FINGERS = 8,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] move_dx,
    input  logic signed [COORD_WIDTH-1:0] move_dy,
    input  logic [7:0]                    finger_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    kind,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] end_x,
    output logic signed [COORD_WIDTH-1:0] end_y,
    output logic [7:0]                    out_finger,
    output logic signed [COORD_WIDTH-1:0] delta_x,
    output logic signed [COORD_WIDTH-1:0] delta_y,
    output logic signed [COORD_WIDTH+1:0] scale,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [15:0]                   cfg_data
);

    tgr_pkg::dp_cmd_t  cmd;
    tgr_pkg::dp_stat_t stat;
    logic              load;

    // Threshold must be written only while idle (not enforced here), so always ready
    assign cfg_ready = 1'b1;

    tgr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .load      (load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tgr_datapath #(
        .MAX_FINGERS (MAX_FINGERS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .move_dx    (move_dx),
        .move_dy    (move_dy),
        .finger_id  (finger_id),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .out_x      (out_x),
        .out_y      (out_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_finger (out_finger),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .scale      (scale),
        .last       (last)
    );

endmodule
